// ===== sv/ssm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssm_pkg
// types and codes shared by the spring strain monitor modules
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  localparam int unsigned POS_W  = 24;
  localparam int unsigned STR_W  = 16;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned ADJ_W  = 16;
  localparam logic [ADJ_W-1:0] ADJ_RESET = 16'd256;

  typedef enum logic [1:0] {
    V_FINE     = 2'd0,
    V_STRESSED = 2'd1,
    V_BROKEN   = 2'd2,
    V_SKIPPED  = 2'd3
  } ssm_verdict_e;

  typedef enum logic [1:0] {
    OP_SKIP,
    OP_ADD,
    OP_CHECK
  } ssm_op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_SUM,
    S_ROOT,
    S_CMP,
    S_OUT
  } ssm_state_e;

  typedef struct packed {
    logic                    kind;
    logic [IDX_W-1:0]        spring_index;
    logic signed [POS_W-1:0] end_a_x;
    logic signed [POS_W-1:0] end_a_y;
    logic signed [POS_W-1:0] end_b_x;
    logic signed [POS_W-1:0] end_b_y;
    logic [POS_W-1:0]        rest_length;
    logic [STR_W-1:0]        strength;
  } ssm_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] index_out;
    ssm_verdict_e     verdict;
    logic             stress_event;
    logic             break_event;
  } ssm_out_t;

  // classified request between front and back
  typedef struct packed {
    ssm_op_e          op;
    logic [IDX_W-1:0] index;
    logic [POS_W-1:0] dx;
    logic [POS_W-1:0] dy;
    logic [POS_W-1:0] rest;
    logic [STR_W-1:0] strength;
  } ssm_req_t;

  typedef struct packed {
    logic push;
    logic full;
  } ssm_push_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } ssm_pop_t;

endpackage

// ===== sv/ssm_front.sv =====
// ----------------------------------------------------------------------------
// ssm_front
// accepts requests, classifies them and forms the endpoint distances
// ----------------------------------------------------------------------------
module ssm_front #(
  parameter int MAX_SPRINGS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             busy_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ssm_pkg::ssm_in_t in_req_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output ssm_pkg::ssm_req_t q_req_o
);
  import ssm_pkg::*;

  logic     fr_valid_q, fr_valid_d;
  ssm_req_t fr_req_q, fr_req_d;
  logic     accept;
  logic signed [POS_W:0] diff_x, diff_y;
  logic signed [POS_W:0] abs_x, abs_y;

  assign q_push_o   = fr_valid_q && !q_full_i;
  assign in_stall_o = busy_i || (fr_valid_q && q_full_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign q_req_o    = fr_req_q;

  always_comb begin
    diff_x = {in_req_i.end_a_x[POS_W-1], in_req_i.end_a_x}
           - {in_req_i.end_b_x[POS_W-1], in_req_i.end_b_x};
    diff_y = {in_req_i.end_a_y[POS_W-1], in_req_i.end_a_y}
           - {in_req_i.end_b_y[POS_W-1], in_req_i.end_b_y};
    abs_x  = diff_x[POS_W] ? -diff_x : diff_x;
    abs_y  = diff_y[POS_W] ? -diff_y : diff_y;

    fr_req_d.index    = in_req_i.spring_index;
    fr_req_d.dx       = abs_x[POS_W-1:0];
    fr_req_d.dy       = abs_y[POS_W-1:0];
    fr_req_d.rest     = in_req_i.rest_length;
    fr_req_d.strength = in_req_i.strength;
    if (32'(in_req_i.spring_index) >= 32'(MAX_SPRINGS)) begin
      fr_req_d.op = OP_SKIP;
    end else if (in_req_i.kind == KIND_ADD) begin
      fr_req_d.op = OP_ADD;
    end else begin
      fr_req_d.op = OP_CHECK;
    end

    fr_valid_d = fr_valid_q;
    if (accept) begin
      fr_valid_d = 1'b1;
    end else if (q_push_o) begin
      fr_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fr_req_q <= fr_req_d;
    end
  end

endmodule

// ===== sv/ssm_queue.sv =====
// ----------------------------------------------------------------------------
// ssm_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module ssm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ssm_pkg::ssm_req_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output ssm_pkg::ssm_req_t data_o
);
  import ssm_pkg::*;

  ssm_req_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/ssm_back.sv =====
// ----------------------------------------------------------------------------
// ssm_back
// flag table, iterative square root, strain bounds and result register
// ----------------------------------------------------------------------------
module ssm_back #(
  parameter int MAX_SPRINGS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ssm_pkg::ADJ_W-1:0]      adj_i,
  input  logic                           q_empty_i,
  input  ssm_pkg::ssm_req_t              q_req_i,
  output logic                           q_pop_o,
  output logic                           busy_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ssm_pkg::ssm_out_t              out_res_o
);
  import ssm_pkg::*;

  localparam int AW     = (MAX_SPRINGS > 1) ? $clog2(MAX_SPRINGS) : 1;
  localparam int SQ_W   = 2 * POS_W;
  localparam int OPND_W = 2 * (POS_W + 1);
  localparam int ROOT_W = POS_W + 1;
  localparam int REM_W  = ROOT_W + 4;
  localparam int EA_W   = ADJ_W + STR_W;
  localparam int BND_W  = EA_W + POS_W;
  localparam int LHS_W  = ROOT_W + 16 + 1;

  // flag entry: {deleted, stressed}
  logic [1:0]         flags_mem [MAX_SPRINGS];
  logic [1:0]         rd_data_q;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               rd_en, wr_en;
  logic [1:0]         wr_data;

  ssm_state_e         state_q, state_d;
  logic [AW-1:0]      clr_cnt_q;
  ssm_req_t           req_q;
  logic [1:0]         flags_q;
  logic [SQ_W-1:0]    sq_x_q, sq_y_q;
  logic [EA_W-1:0]    ea_q;
  logic [BND_W-1:0]   bound_q;
  logic [OPND_W-1:0]  opnd_q;
  logic [REM_W-1:0]   rem_q;
  logic [ROOT_W-1:0]  root_q;
  logic [4:0]         step_q;
  ssm_out_t           res_q, res_d;
  logic               out_valid_q;
  ssm_out_t           out_q;
  logic               out_load;

  logic [REM_W-1:0]   rem_sh, trial;
  logic [ROOT_W-1:0]  dev;
  logic [LHS_W-1:0]   lhs;
  logic               broke, stressed;

  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign busy_o      = (state_q == S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign rd_en       = q_pop_o;
  assign rd_addr     = AW'(q_req_i.index);

  // one root digit per cycle
  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], opnd_q[OPND_W-1 -: 2]};
    trial  = REM_W'({root_q, 2'b01});
  end

  always_comb begin
    dev      = (ROOT_W'(req_q.rest) >= root_q) ? ROOT_W'(req_q.rest) - root_q
                                              : root_q - ROOT_W'(req_q.rest);
    lhs      = LHS_W'({dev, 16'b0});
    broke    = BND_W'(lhs) > bound_q;
    stressed = BND_W'({lhs, 1'b0}) > bound_q;
  end

  always_comb begin
    state_d = state_q;
    wr_en   = 1'b0;
    wr_addr = AW'(req_q.index);
    wr_data = 2'b00;
    res_d   = res_q;
    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_q;
        wr_data = 2'b10;
        if (clr_cnt_q == AW'(MAX_SPRINGS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        res_d.index_out    = req_q.index;
        res_d.verdict      = V_SKIPPED;
        res_d.stress_event = 1'b0;
        res_d.break_event  = 1'b0;
        state_d            = S_OUT;
        if (req_q.op == OP_ADD) begin
          wr_en   = 1'b1;
          wr_data = 2'b00;
        end else if (req_q.op == OP_CHECK && !rd_data_q[1]) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        state_d = S_ROOT;
      end
      S_ROOT: begin
        if (step_q == 5'd0) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        wr_en   = 1'b1;
        state_d = S_OUT;
        if (broke) begin
          wr_data           = {1'b1, flags_q[0]};
          res_d.verdict     = V_BROKEN;
          res_d.break_event = 1'b1;
        end else if (stressed) begin
          wr_data            = 2'b01;
          res_d.verdict      = V_STRESSED;
          res_d.stress_event = !flags_q[0];
        end else begin
          wr_data       = 2'b00;
          res_d.verdict = V_FINE;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      flags_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= flags_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (q_pop_o) begin
      req_q <= q_req_i;
    end
    if (state_q == S_LOAD) begin
      flags_q <= rd_data_q;
      sq_x_q  <= req_q.dx * req_q.dx;
      sq_y_q  <= req_q.dy * req_q.dy;
      ea_q    <= adj_i * req_q.strength;
    end
    if (state_q == S_SUM) begin
      opnd_q  <= OPND_W'(sq_x_q) + OPND_W'(sq_y_q);
      rem_q   <= '0;
      root_q  <= '0;
      step_q  <= 5'(ROOT_W - 1);
      bound_q <= ea_q * req_q.rest;
    end
    if (state_q == S_ROOT) begin
      opnd_q <= {opnd_q[OPND_W-3:0], 2'b00};
      step_q <= step_q - 5'd1;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

endmodule

// ===== sv/spring_strain_monitor_core.sv =====
// ----------------------------------------------------------------------------
// spring_strain_monitor_core
// per-spring strain check: length by square root, break and stress verdicts
// ----------------------------------------------------------------------------
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_stall_o    in_req_i   (ssm_in_t)
//   out       output     out_valid_o / out_stall_i  out_res_o  (ssm_out_t)
//   config    input      apb psel/penable/pwrite    pwdata[15:0] strength adj
//
// a check runs the back end states S_LOAD, S_SUM, S_ROOT (one root digit
// per cycle over 25 result bits), S_CMP and S_OUT; add and skipped requests
// go from S_LOAD to S_OUT. after reset a clearing pass marks all
// MAX_SPRINGS slots deleted; in_stall_o is high until it ends. the front
// register and a two-entry queue keep taking requests while a result waits.
// ----------------------------------------------------------------------------
module spring_strain_monitor_core #(
  parameter int MAX_SPRINGS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ssm_pkg::ssm_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ssm_pkg::ssm_out_t out_res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ssm_pkg::*;

  logic [ADJ_W-1:0] adj_q;
  logic             busy;
  ssm_push_t        push_ctl;
  ssm_pop_t         pop_ctl;
  ssm_req_t         fr_req, hd_req;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'b00);
  assign prdata = {16'b0, adj_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q <= ADJ_RESET;
    end else if (cfg_wr) begin
      adj_q <= pwdata[ADJ_W-1:0];
    end
  end

  ssm_front #(.MAX_SPRINGS(MAX_SPRINGS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .busy_i     (busy),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_full_i   (push_ctl.full),
    .q_push_o   (push_ctl.push),
    .q_req_o    (fr_req)
  );

  ssm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_ctl.push),
    .data_i  (fr_req),
    .full_o  (push_ctl.full),
    .pop_i   (pop_ctl.pop),
    .empty_o (pop_ctl.empty),
    .data_o  (hd_req)
  );

  ssm_back #(.MAX_SPRINGS(MAX_SPRINGS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adj_i       (adj_q),
    .q_empty_i   (pop_ctl.empty),
    .q_req_i     (hd_req),
    .q_pop_o     (pop_ctl.pop),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  a_clear_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> in_stall_o)
    else $error("request taken during clearing pass");

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_ctl.full |-> !(push_ctl.push && !pop_ctl.pop))
    else $error("queue overflow");

  a_break_verdict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.break_event |-> out_res_o.verdict == V_BROKEN)
    else $error("break event without broken verdict");

  a_stress_verdict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.stress_event |-> out_res_o.verdict == V_STRESSED)
    else $error("stress event without stressed verdict");

endmodule
